FILE: rtl/pin_record_stream_checker_unit_defines.svh
// Assertion macros for the checker's RTL; the record parser (prsc_back) includes them.
`ifndef PIN_RECORD_STREAM_CHECKER_UNIT_DEFINES_SVH
`define PIN_RECORD_STREAM_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PRSC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PRSC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/prsc_pkg.sv
// Types and constants shared by the pin record stream checker.
package prsc_pkg;

   typedef struct packed {
      logic [7:0] blob_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic       record_end;
      logic       record_good;
      logic [1:0] blob_status;
   } rsp_type;

   // An input item with its tag-byte classification worked out in front.
   typedef struct packed {
      logic [7:0] blob_byte;
      logic       final_byte;
      logic       byte_zero;
      logic       byte_ff;
   } class_type;

   typedef enum logic [2:0] {
      OP_TAG  = 3'd0,
      OP_LEN0 = 3'd1,
      OP_LEN1 = 3'd2,
      OP_LEN2 = 3'd3,
      OP_LEN3 = 3'd4,
      OP_LIST = 3'd5
   } outer_phase_type;

   typedef enum logic [1:0] {
      IP_SIZE_LO = 2'd0,
      IP_SIZE_HI = 2'd1,
      IP_BODY    = 2'd2,
      IP_DONE    = 2'd3
   } inner_phase_type;

   localparam logic [1:0] STATUS_BUSY   = 2'd0;
   localparam logic [1:0] STATUS_OK     = 2'd1;
   localparam logic [1:0] STATUS_REJECT = 2'd2;

   localparam logic [7:0] TAG_RECORD = 8'h00;
   localparam logic [7:0] TAG_END    = 8'hff;

endpackage

FILE: rtl/prsc_fifo.sv
// Two-entry queue built from a head and a tail register.
module prsc_fifo
   #(parameter int WIDTH = 8)
   (
      input  logic             clock,
      input  logic             reset,
      input  logic             push,
      input  logic [WIDTH-1:0] push_data,
      output logic             full,
      input  logic             pop,
      output logic             empty,
      output logic [WIDTH-1:0] head_data
   );

   logic [1:0]       count_ff, count_in;
   logic [WIDTH-1:0] head_ff, head_in;
   logic [WIDTH-1:0] tail_ff, tail_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign empty     = (count_ff == 2'd0);
   assign head_data = head_ff;
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      case (count_ff)
         2'd0: begin
            if (do_push) begin
               head_in  = push_data;
               count_in = 2'd1;
            end
         end
         2'd1: begin
            if (do_push && do_pop) begin
               head_in = push_data;
            end else if (do_push) begin
               tail_in  = push_data;
               count_in = 2'd2;
            end else if (do_pop) begin
               count_in = 2'd0;
            end
         end
         2'd2: begin
            if (do_pop) begin
               head_in = tail_ff;
               if (do_push) begin
                  tail_in = push_data;
               end else begin
                  count_in = 2'd1;
               end
            end
         end
         default: begin
            count_in = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

FILE: rtl/prsc_front.sv
// Input stage: takes items and classifies the byte for the parser.
module prsc_front
   import prsc_pkg::*;
   (
      input  logic      clock,
      input  logic      reset,
      input  logic      push,
      output logic      full,
      input  req_type   req_item,
      output logic      class_push,
      input  logic      class_full,
      output class_type class_item
   );

   logic      valid_ff, valid_in;
   class_type item_ff, item_in;
   logic      take, send;

   assign send       = valid_ff && !class_full;
   assign full       = valid_ff && class_full;
   assign take       = push && !full;
   assign class_push = valid_ff;
   assign class_item = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in             = 1'b1;
         item_in.blob_byte    = req_item.blob_byte;
         item_in.final_byte   = req_item.final_byte;
         item_in.byte_zero    = (req_item.blob_byte == TAG_RECORD);
         item_in.byte_ff      = (req_item.blob_byte == TAG_END);
      end else if (send) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

FILE: rtl/prsc_back.sv
// Record parser: steps the record and item-list state once per item.
module prsc_back
   import prsc_pkg::*;
   (
      input  logic      clock,
      input  logic      reset,
      input  logic      class_empty,
      input  class_type class_item,
      output logic      class_pop,
      input  logic      rsp_full,
      output logic      rsp_push,
      output rsp_type   rsp_item
   );

`include "pin_record_stream_checker_unit_defines.svh"

   outer_phase_type outer_ff, outer_in;
   inner_phase_type inner_ff, inner_in;
   logic [31:0]     length_ff, length_in;
   logic [31:0]     rec_rem_ff, rec_rem_in;
   logic [7:0]      size_low_ff, size_low_in;
   logic [15:0]     item_rem_ff, item_rem_in;
   logic            list_failed_ff, list_failed_in;
   logic            blob_failed_ff, blob_failed_in;

   logic            take;
   logic            accepted;
   logic            is_list;
   logic            rec_end;
   logic            rec_good;
   logic            fail_next;

   assign take      = !class_empty && !rsp_full;
   assign class_pop = take;
   assign rsp_push  = take;

   // Next state.
   always_comb begin
      logic [1:0]  len_idx;
      logic [15:0] size;
      len_idx        = 2'(outer_ff - OP_LEN0);
      size           = {class_item.blob_byte, size_low_ff};
      outer_in       = outer_ff;
      inner_in       = inner_ff;
      length_in      = length_ff;
      rec_rem_in     = rec_rem_ff;
      size_low_in    = size_low_ff;
      item_rem_in    = item_rem_ff;
      list_failed_in = list_failed_ff;
      fail_next      = blob_failed_ff;
      accepted       = 1'b0;
      is_list        = 1'b0;
      rec_end        = 1'b0;
      rec_good       = 1'b0;
      if (take && !blob_failed_ff) begin
         case (outer_ff)
            OP_TAG: begin
               if (class_item.final_byte && class_item.byte_ff) begin
                  accepted = 1'b1;
               end else if (!class_item.byte_zero) begin
                  fail_next = 1'b1;
               end else begin
                  length_in = '0;
                  outer_in  = OP_LEN0;
               end
            end
            OP_LEN0, OP_LEN1, OP_LEN2, OP_LEN3: begin
               length_in[8*len_idx +: 8] = class_item.blob_byte;
               if (outer_ff == OP_LEN3) begin
                  if (length_in < 32'd2) begin
                     fail_next = 1'b1;
                  end else begin
                     rec_rem_in     = length_in;
                     inner_in       = IP_SIZE_LO;
                     size_low_in    = '0;
                     item_rem_in    = '0;
                     list_failed_in = 1'b0;
                     outer_in       = OP_LIST;
                  end
               end else begin
                  outer_in = outer_phase_type'(outer_ff + 3'd1);
               end
            end
            OP_LIST: begin
               is_list    = 1'b1;
               rec_rem_in = rec_rem_ff - 32'd1;
               case (inner_ff)
                  IP_SIZE_LO: begin
                     size_low_in = class_item.blob_byte;
                     inner_in    = IP_SIZE_HI;
                  end
                  IP_SIZE_HI: begin
                     if (size == 16'd0) begin
                        inner_in = IP_DONE;
                     end else if (size == 16'd1) begin
                        list_failed_in = 1'b1;
                        inner_in       = IP_SIZE_LO;
                     end else begin
                        item_rem_in = size - 16'd2;
                        inner_in    = (size != 16'd2) ? IP_BODY : IP_SIZE_LO;
                     end
                  end
                  IP_BODY: begin
                     item_rem_in = item_rem_ff - 16'd1;
                     if (item_rem_ff == 16'd1) begin
                        inner_in = IP_SIZE_LO;
                     end
                  end
                  default: begin
                     // Bytes after the terminator spoil the list.
                     list_failed_in = 1'b1;
                  end
               endcase
               if (rec_rem_ff == 32'd1) begin
                  rec_end  = 1'b1;
                  rec_good = !list_failed_in && (inner_in == IP_DONE);
                  if (!rec_good) begin
                     fail_next = 1'b1;
                  end
                  outer_in = OP_TAG;
               end else if (class_item.final_byte) begin
                  rec_end = 1'b1;
               end
            end
            default: begin
               fail_next = 1'b1;
            end
         endcase
      end
      blob_failed_in = fail_next;
      // The final item of a blob returns everything to its reset state.
      if (take && class_item.final_byte) begin
         outer_in       = OP_TAG;
         inner_in       = IP_SIZE_LO;
         length_in      = '0;
         rec_rem_in     = '0;
         size_low_in    = '0;
         item_rem_in    = '0;
         list_failed_in = 1'b0;
         blob_failed_in = 1'b0;
      end
   end

   // Result item.
   always_comb begin
      rsp_item.payload_valid = is_list;
      rsp_item.payload_byte  = is_list ? class_item.blob_byte : 8'd0;
      rsp_item.record_end    = rec_end;
      rsp_item.record_good   = rec_good;
      if (class_item.final_byte) begin
         rsp_item.blob_status = (accepted && !fail_next) ? STATUS_OK : STATUS_REJECT;
      end else begin
         rsp_item.blob_status = fail_next ? STATUS_REJECT : STATUS_BUSY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outer_ff       <= OP_TAG;
         inner_ff       <= IP_SIZE_LO;
         list_failed_ff <= 1'b0;
         blob_failed_ff <= 1'b0;
      end else begin
         outer_ff       <= outer_in;
         inner_ff       <= inner_in;
         list_failed_ff <= list_failed_in;
         blob_failed_ff <= blob_failed_in;
      end
      length_ff   <= length_in;
      rec_rem_ff  <= rec_rem_in;
      size_low_ff <= size_low_in;
      item_rem_ff <= item_rem_in;
   end

   `PRSC_ASSERT_NOW(a_good_has_end, rsp_push && rsp_item.record_good, rsp_item.record_end, "record_good without record_end")
   `PRSC_ASSERT_NOW(a_payload_in_list, rsp_push && rsp_item.payload_valid, outer_ff == OP_LIST && !blob_failed_ff, "payload outside a record list")
   `PRSC_ASSERT_NOW(a_ok_on_final, rsp_push && rsp_item.blob_status == STATUS_OK, class_item.final_byte && outer_ff == OP_TAG, "blob accepted away from the final tag")
   `PRSC_ASSERT_NEXT(a_final_clears, take && class_item.final_byte, outer_ff == OP_TAG && !blob_failed_ff && inner_ff == IP_SIZE_LO, "state not cleared after final item")
   `PRSC_ASSERT_NOW(a_list_phase_rem, outer_ff == OP_LIST, rec_rem_ff != 32'd0, "list phase with no bytes left")

endmodule

FILE: rtl/pin_record_stream_checker_unit.sv
// Top level of the pin record stream checker.
// The checker takes one blob byte per item and returns one result item per input item, in order,
// at a sustained rate of one item per clock cycle when nothing stalls. An accepted item passes a
// classifying input register, a two-entry queue, the record parser, which forms its result
// combinationally, and a two-entry result queue, whose head register drives the rsp ports;
// either side may stall without stopping the other until the queues fill. The parser's
// one-step update of the record and item-list counters sets the rate.
module pin_record_stream_checker_unit
   import prsc_pkg::*;
   (
      input  logic    clock,
      input  logic    reset,
      input  logic    push,
      output logic    full,
      input  req_type req_item,
      output logic    empty,
      input  logic    pop,
      output rsp_type rsp_item
   );

   class_type class_in_item;
   class_type class_out_item;
   logic      class_push, class_full, class_pop, class_empty;
   logic      rsp_push, rsp_full;
   rsp_type   rsp_new_item;

   prsc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_item   (req_item),
      .class_push (class_push),
      .class_full (class_full),
      .class_item (class_in_item)
   );

   prsc_fifo #(.WIDTH($bits(class_type))) u_class_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (class_push),
      .push_data (class_in_item),
      .full      (class_full),
      .pop       (class_pop),
      .empty     (class_empty),
      .head_data (class_out_item)
   );

   prsc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .class_empty (class_empty),
      .class_item  (class_out_item),
      .class_pop   (class_pop),
      .rsp_full    (rsp_full),
      .rsp_push    (rsp_push),
      .rsp_item    (rsp_new_item)
   );

   prsc_fifo #(.WIDTH($bits(rsp_type))) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_new_item),
      .full      (rsp_full),
      .pop       (pop),
      .empty     (empty),
      .head_data (rsp_item)
   );

endmodule
